/* rtl/rlab_pkg.sv */
package rlab_pkg;

  localparam int unsigned ChanW  = 8;
  localparam int unsigned LmsW   = 17;
  localparam int unsigned LogW   = 22;
  localparam int unsigned OutW   = 16;
  localparam int unsigned FracW  = 16;
  localparam int unsigned MantW  = 31;

  localparam logic [15:0] RL_Q16 = 16'd24976;
  localparam logic [15:0] GL_Q16 = 16'd37899;
  localparam logic [15:0] BL_Q16 = 16'd2635;
  localparam logic [15:0] RM_Q16 = 16'd12891;
  localparam logic [15:0] GM_Q16 = 16'd47474;
  localparam logic [15:0] BM_Q16 = 16'd5125;
  localparam logic [15:0] RS_Q16 = 16'd1579;
  localparam logic [15:0] GS_Q16 = 16'd8441;
  localparam logic [15:0] BS_Q16 = 16'd55339;
  localparam logic [15:0] LOG10_2_Q16   = 16'd19728;
  localparam logic [15:0] INV_SQRT3_Q16 = 16'd37837;
  localparam logic [15:0] INV_SQRT6_Q16 = 16'd26755;
  localparam logic [15:0] INV_SQRT2_Q16 = 16'd46341;

  // stages: 1 lms, 2 normalise, 3..18 one log2 fraction bit each,
  // 19 log10 scale, 20 decorrelate, 21 round and saturate
  localparam int unsigned NumStages = 21;

endpackage

/* rtl/rgb_to_lab_ruderman_space.sv */
// rgb to l-alpha-beta colour converter, one pixel per item
// in_tdata : red [7:0], green [15:8], blue [23:16]
// out_tdata: lightness [15:0], alpha [31:16], beta [47:32], signed q4.12
// the block holds no state between pixels; results are saturated
// throughput is one item per cycle unless out_tready stalls it, set by the
// 21-stage pipeline with one register per step: lms matrix, leading-one
// normalise, sixteen squaring steps that each yield one bit of the log2
// fraction, log10 scaling, decorrelating multiply and rounding with
// saturation
// the whole pipeline advances only when the last stage is empty or taken,
// so a stall on out_tready freezes every stage and drops or repeats nothing;
// in_tready is low only while the output is full and not taken
// rst_n (synchronous, active low) clears all valid bits; payload registers
// are not reset
module rgb_to_lab_ruderman_space (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // red, green, blue
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // lightness, alpha, beta
);
  import rlab_pkg::*;

  typedef logic [MantW-1:0] mant_t;

  logic               adv;
  logic [NumStages-1:0] vld_r;

  // stage 1
  logic [LmsW-1:0] lms_r [3];
  // stage 2 .. 18 per component
  mant_t           x_r   [3][17];
  logic [4:0]      p_r   [3][17];
  logic            z_r   [3][17];
  logic [FracW-1:0] f_r  [3][17];
  // stage 19
  logic signed [LogW-1:0] lg_r [3];
  // stage 20
  logic signed [40:0] acc_r [3];
  // stage 21
  logic [OutW-1:0] o_r [3];

  assign adv       = !vld_r[NumStages-1] || out_tready;
  assign in_tready = adv;
  assign out_tvalid = vld_r[NumStages-1];
  assign out_tdata  = {o_r[2], o_r[1], o_r[0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NumStages-2:0], in_tvalid};
    end
  end

  function automatic logic [LmsW-1:0] lms_f(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b, input logic [15:0] cr,
                                          input logic [15:0] cg, input logic [15:0] cb);
    logic [25:0] s;
    s = 26'(cr * r) + 26'(cg * g) + 26'(cb * b) + 26'd128;
    return s[8 +: LmsW];
  endfunction

  function automatic logic [4:0] msb_f(input logic [LmsW-1:0] v);
    logic [4:0] p;
    p = '0;
    for (int i = 0; i < LmsW; i++) if (v[i]) p = 5'(i);
    return p;
  endfunction

  function automatic logic signed [40:0] rsh_f(input logic signed [40:0] v,
                                               input int unsigned s);
    logic signed [40:0] half;
    logic signed [40:0] m;
    half = 41'sd1 <<< (s - 1);
    m = v[40] ? -v : v;
    m = (m + half) >>> s;
    return v[40] ? -m : m;
  endfunction

  logic signed [40:0] l2_w [3];
  logic signed [40:0] sum_w [3];
  logic signed [40:0] rnd_w [3];
  logic [61:0] sq_w [3][16];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      l2_w[c] = 41'($signed({1'b0, p_r[c][16]}) - 41'sd8) * 41'sd65536
                + 41'($unsigned(f_r[c][16]));
      for (int k = 0; k < 16; k++) sq_w[c][k] = x_r[c][k] * x_r[c][k];
    end
    sum_w[0] = 41'(lg_r[0]) + 41'(lg_r[1]) + 41'(lg_r[2]);
    sum_w[1] = 41'(lg_r[0]) + 41'(lg_r[1]) - 41'(lg_r[2]) - 41'(lg_r[2]);
    sum_w[2] = 41'(lg_r[0]) - 41'(lg_r[1]);
    for (int c = 0; c < 3; c++) rnd_w[c] = rsh_f(acc_r[c], 20);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lms_r[0] <= lms_f(in_tdata[7:0], in_tdata[15:8], in_tdata[23:16],
                        RL_Q16, GL_Q16, BL_Q16);
      lms_r[1] <= lms_f(in_tdata[7:0], in_tdata[15:8], in_tdata[23:16],
                        RM_Q16, GM_Q16, BM_Q16);
      lms_r[2] <= lms_f(in_tdata[7:0], in_tdata[15:8], in_tdata[23:16],
                        RS_Q16, GS_Q16, BS_Q16);
      for (int c = 0; c < 3; c++) begin
        // normalise mantissa to q1.30
        p_r[c][0] <= msb_f(lms_r[c]);
        z_r[c][0] <= (lms_r[c] == '0);
        x_r[c][0] <= mant_t'({14'd0, lms_r[c]} << (5'd30 - msb_f(lms_r[c])));
        f_r[c][0] <= '0;
        for (int k = 0; k < 16; k++) begin
          p_r[c][k+1] <= p_r[c][k];
          z_r[c][k+1] <= z_r[c][k];
          // square, one fraction bit per stage
          if (sq_w[c][k][61]) begin
            x_r[c][k+1] <= mant_t'(sq_w[c][k][61:31]);
            f_r[c][k+1] <= f_r[c][k] | (FracW'(1) << (15 - k));
          end else begin
            x_r[c][k+1] <= mant_t'(sq_w[c][k][60:30]);
            f_r[c][k+1] <= f_r[c][k];
          end
        end
        lg_r[c] <= z_r[c][16] ? '0
                   : LogW'(rsh_f(41'(l2_w[c] * $signed({1'b0, LOG10_2_Q16})), 16));
      end
      acc_r[0] <= sum_w[0] * $signed({25'd0, INV_SQRT3_Q16});
      acc_r[1] <= sum_w[1] * $signed({25'd0, INV_SQRT6_Q16});
      acc_r[2] <= sum_w[2] * $signed({25'd0, INV_SQRT2_Q16});
      for (int c = 0; c < 3; c++) begin
        if (rnd_w[c] > 41'sd32767) o_r[c] <= 16'h7fff;
        else if (rnd_w[c] < -41'sd32768) o_r[c] <= 16'h8000;
        else o_r[c] <= rnd_w[c][15:0];
      end
    end
  end

endmodule
